// ----- rtl/core/rrma_pkg.sv -----
// shared constants for the round-robin converter moving-average filter
// no dependencies; imported by round_robin_adc_moving_average
package rrma_pkg;

    localparam int CHANNELS_DEF = 9;
    localparam int TAPS_DEF     = 8;

    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 4;

endpackage

// ----- rtl/core/round_robin_adc_moving_average.sv -----
// round-robin multichannel moving-average filter for a converter stream
// depends on rrma_pkg; holds the sample ring and per-channel sum memories
//
//   channel   direction   handshake            payload
//   in        to block    in_valid / in_stall   raw_conversion
//   out       from block  out_valid / out_stall channel, average, next_mux_select
//
// one request per cycle while out_stall is low; results pass registers s1, s2 and out
// the rate is set by the single read-modify-write port pair of the ring and sum memories
// after reset a pass over all CHANNELS*TAPS entries zeroes both memories, in_stall high
// pipeline stages advance independently, so bubbles close up while out_stall is high
// in_stall rises once every stage holds a request and the output is stalled
module round_robin_adc_moving_average #(
    parameter int CHANNELS = rrma_pkg::CHANNELS_DEF,
    parameter int TAPS     = rrma_pkg::TAPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rrma_pkg::RAW_W-1:0]    raw_conversion,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrma_pkg::CHAN_W-1:0]   channel,
    output logic [rrma_pkg::SAMPLE_W-1:0] average,
    output logic [rrma_pkg::CHAN_W-1:0]   next_mux_select
);
    import rrma_pkg::*;

    localparam int RING_DEPTH = CHANNELS * TAPS;
    localparam int RA_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int P_W        = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int TAP_L      = $clog2(TAPS);
    localparam int SUM_W      = SAMPLE_W + TAP_L;
    localparam int RECIP_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int SHIFT      = SUM_W + TAP_L;

    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [CH_W-1:0]    CH_LAST   = CH_W'(CHANNELS - 1);
    localparam logic [P_W-1:0]     P_LAST    = P_W'(TAPS - 1);
    localparam logic [RA_W-1:0]    TAPS_A    = RA_W'(TAPS);
    localparam logic [RA_W-1:0]    RING_LAST = RA_W'(RING_DEPTH - 1);
    localparam logic [RA_W:0]      CH_COUNT  = (RA_W + 1)'(CHANNELS);

    // memories
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SUM_W-1:0]    sum_mem  [CHANNELS];

    // control state
    logic            clear_reg;
    logic [RA_W-1:0] clr_addr_reg;
    logic [CH_W-1:0] cur_reg;
    logic [P_W-1:0]  pos_reg;
    logic [RA_W-1:0] base_reg;
    logic            s1_valid_reg;
    logic            s2_valid_reg;
    logic            out_valid_reg;
    logic            fwd_ring_reg;
    logic            fwd_sum_reg;

    // payload
    logic [CH_W-1:0]     s1_ch_reg;
    logic [CH_W-1:0]     s1_next_reg;
    logic [RA_W-1:0]     s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [SAMPLE_W-1:0] ring_rd_reg;
    logic [SUM_W-1:0]    sum_rd_reg;
    logic [SAMPLE_W-1:0] fwd_ring_val_reg;
    logic [SUM_W-1:0]    fwd_sum_val_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic [CH_W-1:0]     s2_next_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [CHAN_W-1:0]   ch_out_reg;
    logic [SAMPLE_W-1:0] avg_out_reg;
    logic [CHAN_W-1:0]   next_out_reg;

    logic                out_free;
    logic                s2_free;
    logic                s2_move;
    logic                s1_free;
    logic                s1_move;
    logic                accept;
    logic [RA_W-1:0]     ring_addr;
    logic [CH_W-1:0]     next_ch;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    old_sum;
    logic [SUM_W-1:0]    new_sum;
    logic                ring_we;
    logic [RA_W-1:0]     ring_wa;
    logic [SAMPLE_W-1:0] ring_wd;
    logic                sum_we;
    logic [CH_W-1:0]     sum_wa;
    logic [SUM_W-1:0]    sum_wd;
    logic [PROD_W-1:0]   prod;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_move  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = clear_reg || !s1_free;
    assign accept   = in_valid && !in_stall;

    assign ring_addr = base_reg + RA_W'(pos_reg);
    assign next_ch   = (cur_reg == CH_LAST) ? '0 : cur_reg + 1'b1;

    // the entry written by the leaving request overrides the stale read
    assign old_sample = fwd_ring_reg ? fwd_ring_val_reg : ring_rd_reg;
    assign old_sum    = fwd_sum_reg ? fwd_sum_val_reg : sum_rd_reg;
    assign new_sum    = old_sum - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);

    always_comb
    begin
        if (clear_reg)
        begin
            ring_we = 1'b1;
            ring_wa = clr_addr_reg;
            ring_wd = '0;
            sum_we  = ({1'b0, clr_addr_reg} < CH_COUNT);
            sum_wa  = clr_addr_reg[CH_W-1:0];
            sum_wd  = '0;
        end
        else
        begin
            ring_we = s1_move;
            ring_wa = s1_addr_reg;
            ring_wd = s1_sample_reg;
            sum_we  = s1_move;
            sum_wa  = s1_ch_reg;
            sum_wd  = new_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (accept)
        begin
            ring_rd_reg <= ring_mem[ring_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (accept)
        begin
            sum_rd_reg <= sum_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_addr_reg  <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            base_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_ring_reg  <= 1'b0;
            fwd_sum_reg   <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == RING_LAST)
                begin
                    clear_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                cur_reg      <= next_ch;
                fwd_ring_reg <= s1_move && (s1_addr_reg == ring_addr);
                fwd_sum_reg  <= s1_move && (s1_ch_reg == cur_reg);
                if (cur_reg == CH_LAST)
                begin
                    base_reg <= '0;
                    pos_reg  <= (pos_reg == P_LAST) ? '0 : pos_reg + 1'b1;
                end
                else
                begin
                    base_reg <= base_reg + TAPS_A;
                end
            end

            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_move;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_move;
            end
        end
    end

    assign prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg        <= cur_reg;
            s1_next_reg      <= next_ch;
            s1_addr_reg      <= ring_addr;
            s1_sample_reg    <= raw_conversion[SAMPLE_W-1:0];
            fwd_ring_val_reg <= s1_sample_reg;
            fwd_sum_val_reg  <= new_sum;
        end
        if (s1_move)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_next_reg <= s1_next_reg;
            s2_sum_reg  <= new_sum;
        end
        if (s2_move)
        begin
            ch_out_reg   <= CHAN_W'(s2_ch_reg);
            next_out_reg <= CHAN_W'(s2_next_reg);
            avg_out_reg  <= prod[SHIFT +: SAMPLE_W];
        end
    end

    assign out_valid       = out_valid_reg;
    assign channel         = ch_out_reg;
    assign average         = avg_out_reg;
    assign next_mux_select = next_out_reg;

endmodule
